### hw/rtl/ray_triangle_nearest_hit_core_assert.svh
// Assertion macros shared by the ray/triangle nearest-hit core.
// Depends on nothing; included by the top level only.
`ifndef RAY_TRIANGLE_NEAREST_HIT_CORE_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_CORE_ASSERT_SVH
`define RTN_ASSERT_IMPL(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define RTN_ASSERT_NEXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/rtnh_pkg.sv
// Types and constants for the ray/triangle nearest-hit core.
// Depends on nothing.
package rtnh_pkg;
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] RegOrgX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegOrgY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegOrgZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegDirX = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDirY = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegDirZ = 3'd5;
  localparam int unsigned WideBits = 128;
  localparam int unsigned DistBits = 31;
  localparam logic [DistBits-1:0] DistMax = '1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCalc  = 6'b000010,
    StDiv   = 6'b000100,
    StUpd   = 6'b001000,
    StOut   = 6'b010000,
    StWait  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic calc_step;
    logic div_start;
    logic update;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic calc_done;
    logic div_done;
    logic last;
  } stat_t;
endpackage

### hw/rtl/rtnh_ctrl.sv
// Controller state machine of the ray/triangle nearest-hit core.
// Depends on rtnh_pkg.
module rtnh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rtnh_pkg::cmd_t cmd_o,
  input  rtnh_pkg::stat_t stat_i
);
  import rtnh_pkg::*;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc_step = 1'b1;
        if (stat_i.calc_done) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (stat_i.div_done) state_d = StUpd;
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = stat_i.last ? StOut : StIdle;
      end
      StOut: begin
        if (!out_stall_i) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule

### hw/rtl/rtnh_datapath.sv
// Datapath of the ray/triangle nearest-hit core: a sequenced multiply unit,
// a bit-serial divider and the running best-hit registers. Depends on rtnh_pkg.
module rtnh_datapath #(
  parameter int unsigned FaceIdBits = 16,
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtnh_pkg::cmd_t       cmd_i,
  output rtnh_pkg::stat_t      stat_o,
  input  logic signed [31:0]   org_i [3],
  input  logic signed [17:0]   dir_i [3],
  input  logic signed [31:0]   v0_i [3],
  input  logic signed [31:0]   v1_i [3],
  input  logic signed [31:0]   v2_i [3],
  input  logic [15:0]          face_i,
  input  logic                 last_i,
  output logic                 hit_o,
  output logic [15:0]          face_o,
  output logic [30:0]          dist_o
);
  import rtnh_pkg::*;
  localparam int unsigned StepBits = 5;
  localparam int unsigned HalfBits = 34;
  localparam logic [WideBits-1:0] Eps = WideBits'((128'd1 << (3*FracBits - 10)) / 9765625);
  localparam logic [DistBits-1:0] TMin = DistBits'((64'd1 << (FracBits - 6)) / 15625);
  localparam logic [7:0] DivSteps = 8'd128;
  localparam logic [StepBits-1:0] LastStep = 5'd23;

  logic signed [32:0] e1_q [3], e2_q [3], s_q [3];
  logic signed [17:0] d_q [3];
  logic signed [WideBits-1:0] h_q [3], qv_q [3];
  logic signed [WideBits-1:0] a_q, sn_q, vn_q, tn_q;
  logic [15:0] face_q;
  logic last_q;
  logic [StepBits-1:0] step_q;
  logic half_q;
  logic signed [WideBits-1:0] prod_q;
  logic signed [67:0] plo_q;
  logic [StepBits-1:0] pstep_q;
  logic pvalid_q;

  // Each product is built from two 33x35-bit partial products on
  // consecutive cycles, low half of the second operand first.
  logic signed [32:0] ma;
  logic signed [67:0] mb;
  logic signed [34:0] mop;
  logic signed [67:0] mul;
  always_comb begin
    ma = '0; mb = '0;
    case (step_q)
      5'd0:  begin ma = 33'(d_q[1]); mb = 68'(e2_q[2]); end
      5'd1:  begin ma = 33'(d_q[2]); mb = 68'(e2_q[1]); end
      5'd2:  begin ma = 33'(d_q[2]); mb = 68'(e2_q[0]); end
      5'd3:  begin ma = 33'(d_q[0]); mb = 68'(e2_q[2]); end
      5'd4:  begin ma = 33'(d_q[0]); mb = 68'(e2_q[1]); end
      5'd5:  begin ma = 33'(d_q[1]); mb = 68'(e2_q[0]); end
      5'd6:  begin ma = s_q[1];      mb = 68'(e1_q[2]); end
      5'd7:  begin ma = s_q[2];      mb = 68'(e1_q[1]); end
      5'd8:  begin ma = s_q[2];      mb = 68'(e1_q[0]); end
      5'd9:  begin ma = s_q[0];      mb = 68'(e1_q[2]); end
      5'd10: begin ma = s_q[0];      mb = 68'(e1_q[1]); end
      5'd11: begin ma = s_q[1];      mb = 68'(e1_q[0]); end
      5'd12: begin ma = e1_q[0];     mb = h_q[0][67:0]; end
      5'd13: begin ma = e1_q[1];     mb = h_q[1][67:0]; end
      5'd14: begin ma = e1_q[2];     mb = h_q[2][67:0]; end
      5'd15: begin ma = s_q[0];      mb = h_q[0][67:0]; end
      5'd16: begin ma = s_q[1];      mb = h_q[1][67:0]; end
      5'd17: begin ma = s_q[2];      mb = h_q[2][67:0]; end
      5'd18: begin ma = 33'(d_q[0]); mb = qv_q[0][67:0]; end
      5'd19: begin ma = 33'(d_q[1]); mb = qv_q[1][67:0]; end
      5'd20: begin ma = 33'(d_q[2]); mb = qv_q[2][67:0]; end
      5'd21: begin ma = e2_q[0];     mb = qv_q[0][67:0]; end
      5'd22: begin ma = e2_q[1];     mb = qv_q[1][67:0]; end
      5'd23: begin ma = e2_q[2];     mb = qv_q[2][67:0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    mop = half_q ? {mb[67], mb[67:HalfBits]} : {1'b0, mb[HalfBits-1:0]};
    mul = ma * mop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      half_q <= 1'b0;
      pvalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      step_q <= '0;
      half_q <= 1'b0;
      pvalid_q <= 1'b0;
    end else if (cmd_i.calc_step) begin
      if (step_q <= LastStep) begin
        half_q <= ~half_q;
        pvalid_q <= half_q;
        if (half_q) step_q <= step_q + 5'd1;
      end else begin
        pvalid_q <= 1'b0;
      end
    end
  end

  // A product's accumulate comes in the cycle after its second half; later
  // products read h and q only after those are complete.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_step && (step_q <= LastStep)) begin
      if (half_q) begin
        prod_q <= (WideBits'(mul) <<< HalfBits) + WideBits'(plo_q);
        pstep_q <= step_q;
      end else begin
        plo_q <= mul;
      end
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= 33'(v1_i[i]) - 33'(v0_i[i]);
        e2_q[i] <= 33'(v2_i[i]) - 33'(v0_i[i]);
        s_q[i]  <= 33'(org_i[i]) - 33'(v0_i[i]);
        d_q[i]  <= dir_i[i];
      end
      face_q <= face_i;
      last_q <= last_i;
    end else if (cmd_i.calc_step && pvalid_q) begin
      case (pstep_q)
        5'd0:  h_q[0]  <= prod_q;
        5'd1:  h_q[0]  <= h_q[0] - prod_q;
        5'd2:  h_q[1]  <= prod_q;
        5'd3:  h_q[1]  <= h_q[1] - prod_q;
        5'd4:  h_q[2]  <= prod_q;
        5'd5:  h_q[2]  <= h_q[2] - prod_q;
        5'd6:  qv_q[0] <= prod_q;
        5'd7:  qv_q[0] <= qv_q[0] - prod_q;
        5'd8:  qv_q[1] <= prod_q;
        5'd9:  qv_q[1] <= qv_q[1] - prod_q;
        5'd10: qv_q[2] <= prod_q;
        5'd11: qv_q[2] <= qv_q[2] - prod_q;
        5'd12: a_q  <= prod_q;
        5'd13: a_q  <= a_q + prod_q;
        5'd14: a_q  <= a_q + prod_q;
        5'd15: sn_q <= prod_q;
        5'd16: sn_q <= sn_q + prod_q;
        5'd17: sn_q <= sn_q + prod_q;
        5'd18: vn_q <= prod_q;
        5'd19: vn_q <= vn_q + prod_q;
        5'd20: vn_q <= vn_q + prod_q;
        5'd21: tn_q <= prod_q;
        5'd22: tn_q <= tn_q + prod_q;
        5'd23: tn_q <= tn_q + prod_q;
        default: ;
      endcase
    end
  end

  // Products for h must land before step 12 reads them: the accumulate for
  // step 5 happens while step 6 multiplies, so h is final by step 12.
  // The sums are final once the last accumulate has been written back.
  assign stat_o.calc_done = !pvalid_q && (step_q == LastStep + 5'd1);
  assign stat_o.last = last_q;

  logic signed [WideBits-1:0] aa, sa, va, ta;
  logic neg;
  assign neg = a_q[WideBits-1];
  assign aa = neg ? -a_q : a_q;
  assign sa = neg ? -sn_q : sn_q;
  assign va = neg ? -vn_q : vn_q;
  assign ta = neg ? -tn_q : tn_q;

  logic signed [WideBits-1:0] uv;
  logic ok;
  assign uv = sa + va;
  assign ok = (aa != '0) && !(aa < Eps) && !sa[WideBits-1] && !(aa < sa)
           && !va[WideBits-1] && !(aa < uv) && !ta[WideBits-1] && (ta != '0);

  // Restoring divider, one quotient bit per cycle over the 128-bit numerator.
  logic [WideBits-1:0] num_q, den_q, quo_q;
  logic [WideBits:0] rem_q, rem_sh;
  logic [7:0] cnt_q;
  logic busy_q, ok_q;
  assign rem_sh = {rem_q[WideBits-1:0], num_q[WideBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 8'd1;
      if (cnt_q == DivSteps - 8'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= ta << FracBits;
      den_q <= aa;
      quo_q <= '0;
      rem_q <= '0;
      ok_q <= ok;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[WideBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[WideBits-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = !busy_q;

  logic [DistBits-1:0] t_sat;
  assign t_sat = (quo_q[WideBits-1:DistBits] != '0) ? DistMax : quo_q[DistBits-1:0];

  logic [DistBits-1:0] best_q;
  logic [15:0] bface_q;
  logic any_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= DistMax;
      bface_q <= '0;
      any_q <= 1'b0;
    end else if (cmd_i.clear) begin
      best_q <= DistMax;
      bface_q <= '0;
      any_q <= 1'b0;
    end else if (cmd_i.update && ok_q && t_sat > TMin && t_sat < best_q) begin
      best_q <= t_sat;
      bface_q <= 16'(face_q[((FaceIdBits > 16) ? 15 : FaceIdBits-1):0]);
      any_q <= 1'b1;
    end
  end
  assign hit_o = any_q;
  assign face_o = any_q ? bface_q : '0;
  assign dist_o = any_q ? best_q : '0;
endmodule

### hw/rtl/ray_triangle_nearest_hit_core.sv
// Top level of the ray/triangle nearest-hit core.
// Depends on rtnh_pkg, rtnh_ctrl, rtnh_datapath and the assertion header.
//
// channel   direction  handshake
// in        input      in_valid_i / in_stall_o, triangle word
// out       output     out_valid_o / out_stall_i, nearest-hit word
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i
//
// A triangle holds the input off while it is loaded, its 24 products are formed
// (two 33x35-bit partial products each, then the last sum settles), the
// one-bit-per-cycle divider runs and the best hit is updated.
// Only one triangle is in flight; a last triangle adds the StOut state, which
// lasts as long as the output is stalled.
// Reset clears the running best hit and restores the default ray.
`include "ray_triangle_nearest_hit_core_assert.svh"
module ray_triangle_nearest_hit_core #(
  parameter int unsigned FACE_ID_BITS = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vert0_x_i, vert0_y_i, vert0_z_i,
  input  logic signed [31:0] vert1_x_i, vert1_y_i, vert1_z_i,
  input  logic signed [31:0] vert2_x_i, vert2_y_i, vert2_z_i,
  input  logic [15:0]        face_id_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_found_o,
  output logic [15:0]        nearest_face_o,
  output logic [30:0]        nearest_distance_o
);
  import rtnh_pkg::*;
  logic signed [31:0] org_q [3];
  logic signed [17:0] dir_q [3];
  logic signed [31:0] v0 [3], v1 [3], v2 [3];
  cmd_t cmd;
  stat_t stat;

  assign v0 = '{vert0_x_i, vert0_y_i, vert0_z_i};
  assign v1 = '{vert1_x_i, vert1_y_i, vert1_z_i};
  assign v2 = '{vert2_x_i, vert2_y_i, vert2_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
      dir_q[0] <= '0; dir_q[1] <= '0; dir_q[2] <= 18'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOrgX: org_q[0] <= cfg_data_i;
        RegOrgY: org_q[1] <= cfg_data_i;
        RegOrgZ: org_q[2] <= cfg_data_i;
        RegDirX: dir_q[0] <= cfg_data_i[17:0];
        RegDirY: dir_q[1] <= cfg_data_i[17:0];
        RegDirZ: dir_q[2] <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  rtnh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .cmd_o(cmd), .stat_i(stat)
  );

  rtnh_datapath #(.FaceIdBits(FACE_ID_BITS), .FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .org_i(org_q), .dir_i(dir_q),
    .v0_i(v0),
    .v1_i(v1),
    .v2_i(v2),
    .face_i(face_id_i), .last_i(is_last_i),
    .hit_o(hit_found_o), .face_o(nearest_face_o), .dist_o(nearest_distance_o)
  );

  `RTN_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `RTN_ASSERT_NEXT(a_clear_after_out, clk_i, rst_ni, out_valid_o && !out_stall_i,
    !hit_found_o && !out_valid_o)
  `RTN_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_found_o,
    nearest_distance_o == '0 && nearest_face_o == '0)
endmodule
